// ===== src/dvru_pkg.sv =====
`timescale 1ns / 1ps
package dvru_pkg;

    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int LINK_DEPTH_DEF    = 8;
    localparam int INF_DIST_DEF      = 16;
    localparam int TIMEOUT_TICKS_DEF = 5;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_ADV = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    typedef enum logic [3:0] {
        ST_INFINITE  = 4'd0,
        ST_NO_SENDER = 4'd1,
        ST_INSERTED  = 4'd2,
        ST_UPDATED   = 4'd3,
        ST_REFRESHED = 4'd4,
        ST_UNCHANGED = 4'd5,
        ST_FULL      = 4'd6,
        ST_CONNECTED = 4'd7,
        ST_REMOVED   = 4'd8,
        ST_NOT_FOUND = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] net;
        logic [31:0] mask;
        logic [7:0]  metric;
        logic [31:0] hop;
        logic        dead;
        logic [7:0]  timer;
        logic        direct;
    } t_route;

    // Token walking the cell chain: a lookup collects matches and the first
    // free cell, a write drops new contents into the addressed cells or clears one.
    typedef struct packed {
        logic        valid;
        logic        wr;
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic        hit_a;
        t_route      ent_a;
        logic        hit_b;
        t_route      ent_b;
        logic        free;
        logic        kill;
    } t_tok;

endpackage

// ===== src/dvru_cell.sv =====
`timescale 1ns / 1ps
module dvru_cell #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dvru_pkg::t_tok    i_tok,
    input  logic [IDX_W-1:0]  i_idx_a,
    input  logic [IDX_W-1:0]  i_idx_b,
    input  logic [IDX_W-1:0]  i_idx_f,
    output dvru_pkg::t_tok    o_tok,
    output logic [IDX_W-1:0]  o_idx_a,
    output logic [IDX_W-1:0]  o_idx_b,
    output logic [IDX_W-1:0]  o_idx_f
);
    import dvru_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             r_valid, n_valid;
    t_route           r_ent, n_ent;
    t_tok             r_tok, n_tok;
    logic [IDX_W-1:0] r_ia, n_ia, r_ib, n_ib, r_if, n_if;

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        n_tok   = i_tok;
        n_ia    = i_idx_a;
        n_ib    = i_idx_b;
        n_if    = i_idx_f;
        if (i_tok.valid && i_tok.wr) begin
            if (i_tok.hit_a && i_idx_a == MY_IDX) begin
                if (i_tok.kill) begin
                    n_valid = 1'b0;
                end else begin
                    n_valid = 1'b1;
                    n_ent   = i_tok.ent_a;
                end
            end
            // second write wins on the same slot
            if (i_tok.hit_b && i_idx_b == MY_IDX) begin
                n_valid = 1'b1;
                n_ent   = i_tok.ent_b;
            end
        end else if (i_tok.valid) begin
            if (!i_tok.hit_a && r_valid && r_ent.net == i_tok.key_a) begin
                n_tok.hit_a = 1'b1;
                n_tok.ent_a = r_ent;
                n_ia        = MY_IDX;
            end
            if (!i_tok.hit_b && r_valid && r_ent.net == i_tok.key_b) begin
                n_tok.hit_b = 1'b1;
                n_tok.ent_b = r_ent;
                n_ib        = MY_IDX;
            end
            if (!i_tok.free && !r_valid) begin
                n_tok.free = 1'b1;
                n_if       = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        r_if  <= n_if;
    end

    assign o_tok   = r_tok;
    assign o_idx_a = r_ia;
    assign o_idx_b = r_ib;
    assign o_idx_f = r_if;

endmodule

// ===== src/distance_vector_route_update_unit.sv =====
`timescale 1ns / 1ps
// Distance-vector route table update.
// Command channel: a request word is taken at a clock edge where start is
// high and busy is low. Request kinds: add a connected network, apply a
// route advertisement, remove a route.
// Result channel: one result word per request, shown for exactly one cycle
// with o_valid high. The receiver cannot stall it.
// Route entries live in a row of TABLE_DEPTH cells. A lookup token walks
// the row one cell per cycle, collecting the sender entry, the destination
// entry and the first free slot; a write token follows the same path, so a
// later lookup always sees earlier writes.
// The walk through the cell row comes first, then a scan of the link table
// entry by entry, then the decision. A removal skips the link scan. Unknown
// requests and advertisements at or above the infinity distance answer on
// the next cycle. busy drops in the cycle the result is shown, so the next
// request may be taken at once.
// Reset clears all valid bits of both tables and the control state.
module distance_vector_route_update_unit #(
    parameter int TABLE_DEPTH   = dvru_pkg::TABLE_DEPTH_DEF,
    parameter int LINK_DEPTH    = dvru_pkg::LINK_DEPTH_DEF,
    parameter int INF_DIST      = dvru_pkg::INF_DIST_DEF,
    parameter int TIMEOUT_TICKS = dvru_pkg::TIMEOUT_TICKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_dest_net,
    input  logic [31:0] i_dest_mask,
    input  logic [7:0]  i_route_dist,
    input  logic [31:0] i_nbr_addr,
    input  logic [31:0] i_sender_net,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [7:0]  o_entry_dist,
    output logic [31:0] o_entry_via,
    output logic        o_entry_unreachable
);
    import dvru_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam logic [LW-1:0] LINK_LAST = LW'(LINK_DEPTH - 1);
    localparam logic [7:0]    TMO       = 8'(TIMEOUT_TICKS);
    localparam logic [8:0]    INF9      = 9'(INF_DIST);

    t_state r_state, n_state;

    // request
    logic [1:0]  r_type;
    logic [31:0] r_net, r_mask, r_via, r_snet;
    logic [7:0]  r_dist;

    // lookup results
    logic             r_hit_a, r_hit_b, r_free;
    logic [IDX_W-1:0] r_ia, r_ib, r_if;
    t_route           r_sent, r_dent;

    // link table
    logic             r_lvalid [LINK_DEPTH];
    logic [31:0]      r_lnet   [LINK_DEPTH];
    logic [7:0]       r_ldist  [LINK_DEPTH];
    logic [LW-1:0]    r_lcnt;
    logic             r_lhit, r_lfree;
    logic [LW-1:0]    r_lidx, r_lfidx;

    // result word
    logic        r_ovalid;
    t_status     r_ostatus;
    logic [5:0]  r_oidx;
    logic [7:0]  r_odist;
    logic [31:0] r_ovia;
    logic        r_odead;

    // cell chain
    t_tok             w_tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0] w_ia  [TABLE_DEPTH+1];
    logic [IDX_W-1:0] w_ib  [TABLE_DEPTH+1];
    logic [IDX_W-1:0] w_if  [TABLE_DEPTH+1];

    logic accept, imm, chain_back;

    // decision
    t_status          dec_status;
    logic             dec_has;
    logic [IDX_W-1:0] dec_idx;
    t_route           dec_ent;
    logic             dec_lwr;
    logic [LW-1:0]    dec_lslot;
    t_route           dent, nd, newr;
    logic [8:0]       sum;
    logic             sum_inf;

    assign accept     = start && !busy;
    assign imm        = (i_req_type != REQ_ADD && i_req_type != REQ_ADV &&
                         i_req_type != REQ_DEL) ||
                        (i_req_type == REQ_ADV && {1'b0, i_route_dist} >= INF9);
    assign chain_back = w_tok[TABLE_DEPTH].valid && !w_tok[TABLE_DEPTH].wr;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dvru_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .i_idx_a (w_ia[g]),
                .i_idx_b (w_ib[g]),
                .i_idx_f (w_if[g]),
                .o_tok   (w_tok[g+1]),
                .o_idx_a (w_ia[g+1]),
                .o_idx_b (w_ib[g+1]),
                .o_idx_f (w_if[g+1])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && !imm) n_state = S_LOOK;
            S_LOOK: if (chain_back) n_state = (r_type == REQ_DEL) ? S_DONE : S_LINK;
            S_LINK: if (r_lcnt == LINK_LAST) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // decision on the collected lookup
    always_comb begin
        sum     = {1'b0, r_dist} + {1'b0, r_sent.metric};
        sum_inf = sum >= INF9;
        dent    = (r_hit_a && r_ib == r_ia) ? r_sent : r_dent;
        nd      = dent;
        newr    = '0;
        dec_status = ST_UNCHANGED;
        dec_has    = 1'b0;
        dec_idx    = '0;
        dec_ent    = '0;
        dec_lwr    = 1'b0;
        dec_lslot  = r_lhit ? r_lidx : r_lfidx;
        w_tok[0]      = '0;
        w_tok[0].wr   = 1'b1;
        w_tok[0].kill = 1'b0;
        w_ia[0] = '0;
        w_ib[0] = '0;
        w_if[0] = '0;
        case (r_type)
            REQ_ADD: begin
                newr = '{net: r_net, mask: r_mask, metric: r_dist, hop: 32'd0,
                         dead: 1'b0, timer: TMO, direct: 1'b1};
                if ((r_lhit || r_lfree) && (r_hit_b || r_free)) begin
                    dec_lwr          = 1'b1;
                    dec_status       = ST_CONNECTED;
                    dec_has          = 1'b1;
                    dec_idx          = r_hit_b ? r_ib : r_if;
                    dec_ent          = newr;
                    w_tok[0].hit_a   = 1'b1;
                    w_tok[0].ent_a   = newr;
                    w_ia[0]          = dec_idx;
                end else begin
                    dec_status = ST_FULL;
                end
            end
            REQ_DEL: begin
                if (r_hit_b) begin
                    dec_status     = ST_REMOVED;
                    dec_has        = 1'b1;
                    dec_idx        = r_ib;
                    dec_ent        = r_dent;
                    w_tok[0].hit_a = 1'b1;
                    w_tok[0].kill  = 1'b1;
                    w_ia[0]        = r_ib;
                end else begin
                    dec_status = ST_NOT_FOUND;
                end
            end
            REQ_ADV: begin
                if (!r_hit_a) begin
                    dec_status = ST_NO_SENDER;
                end else begin
                    // keep the sender refresh even when the destination fails
                    w_tok[0].hit_a = 1'b1;
                    w_tok[0].ent_a = r_sent;
                    w_ia[0]        = r_ia;
                    if (!r_hit_b) begin
                        if (r_free) begin
                            newr = '{net: r_net, mask: r_mask,
                                     metric: sum[8] ? 8'hFF : sum[7:0],
                                     hop: r_via, dead: sum_inf, timer: TMO,
                                     direct: 1'b0};
                            dec_status     = ST_INSERTED;
                            dec_has        = 1'b1;
                            dec_idx        = r_if;
                            dec_ent        = newr;
                            w_tok[0].hit_b = 1'b1;
                            w_tok[0].ent_b = newr;
                            w_ib[0]        = r_if;
                        end else begin
                            dec_status = ST_FULL;
                        end
                    end else begin
                        if (sum < {1'b0, dent.metric} || dent.dead) begin
                            if (!sum_inf) begin
                                nd.metric  = sum[7:0];
                                nd.hop     = r_via;
                                nd.timer   = TMO;
                                nd.dead    = 1'b0;
                                dec_status = ST_UPDATED;
                            end
                        end else if (sum == {1'b0, dent.metric} && !sum_inf) begin
                            nd.timer   = TMO;
                            dec_status = ST_REFRESHED;
                        end
                        dec_has        = 1'b1;
                        dec_idx        = r_ib;
                        dec_ent        = nd;
                        w_tok[0].hit_b = 1'b1;
                        w_tok[0].ent_b = nd;
                        w_ib[0]        = r_ib;
                    end
                end
            end
            default: dec_status = ST_UNCHANGED;
        endcase

        // launch tokens into the row
        w_tok[0].valid = 1'b0;
        if (r_state == S_DONE) begin
            w_tok[0].valid = 1'b1;
        end else if (r_state == S_IDLE && accept && !imm) begin
            w_tok[0]       = '0;
            w_tok[0].valid = 1'b1;
            w_tok[0].key_a = (i_req_type == REQ_ADV) ? i_sender_net : i_dest_net;
            w_tok[0].key_b = i_dest_net;
            w_ia[0]        = '0;
            w_ib[0]        = '0;
        end
    end

    // outputs of the state machine
    always_comb begin
        busy = 1'b1;
        unique case (r_state)
            S_IDLE:  busy = 1'b0;
            S_LOOK:  busy = 1'b1;
            S_LINK:  busy = 1'b1;
            S_DONE:  busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < LINK_DEPTH; i++) r_lvalid[i] <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (accept && imm) || r_state == S_DONE;
            if (r_state == S_DONE && dec_lwr) r_lvalid[dec_lslot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_req_type;
            r_net  <= i_dest_net;
            r_mask <= i_dest_mask;
            r_dist <= i_route_dist;
            r_via  <= i_nbr_addr;
            r_snet <= i_sender_net;
            if (imm) begin
                r_ostatus <= (i_req_type == REQ_ADV) ? ST_INFINITE : ST_UNCHANGED;
                r_oidx    <= '0;
                r_odist   <= '0;
                r_ovia    <= '0;
                r_odead   <= 1'b0;
            end
        end
        if (r_state == S_LOOK && chain_back) begin
            r_hit_a <= w_tok[TABLE_DEPTH].hit_a;
            r_sent  <= w_tok[TABLE_DEPTH].ent_a;
            r_ia    <= w_ia[TABLE_DEPTH];
            r_hit_b <= w_tok[TABLE_DEPTH].hit_b;
            r_dent  <= w_tok[TABLE_DEPTH].ent_b;
            r_ib    <= w_ib[TABLE_DEPTH];
            r_free  <= w_tok[TABLE_DEPTH].free;
            r_if    <= w_if[TABLE_DEPTH];
            r_lcnt  <= '0;
            r_lhit  <= 1'b0;
            r_lfree <= 1'b0;
            r_lidx  <= '0;
            r_lfidx <= '0;
        end
        if (r_state == S_LINK) begin
            r_lcnt <= r_lcnt + 1'b1;
            if (r_type == REQ_ADD) begin
                if (!r_lhit && r_lvalid[r_lcnt] && r_lnet[r_lcnt] == r_net) begin
                    r_lhit <= 1'b1;
                    r_lidx <= r_lcnt;
                end
                if (!r_lfree && !r_lvalid[r_lcnt]) begin
                    r_lfree <= 1'b1;
                    r_lfidx <= r_lcnt;
                end
            end else if (r_lvalid[r_lcnt] && r_lnet[r_lcnt] == r_snet) begin
                // refresh the sender route from its link
                if (r_sent.hop != 32'd0) begin
                    if (r_sent.metric >= r_ldist[r_lcnt]) begin
                        r_sent.dead   <= 1'b0;
                        r_sent.timer  <= TMO;
                        r_sent.hop    <= 32'd0;
                        r_sent.metric <= r_ldist[r_lcnt];
                    end
                end else begin
                    r_sent.metric <= r_ldist[r_lcnt];
                    r_sent.dead   <= 1'b0;
                    r_sent.timer  <= TMO;
                end
            end
        end
        if (r_state == S_DONE) begin
            r_ostatus <= dec_status;
            r_oidx    <= dec_has ? 6'(dec_idx) : 6'd0;
            r_odist   <= dec_has ? dec_ent.metric : 8'd0;
            r_ovia    <= dec_has ? dec_ent.hop : 32'd0;
            r_odead   <= dec_has && dec_ent.dead;
            if (dec_lwr) begin
                r_lnet[dec_lslot]  <= r_net;
                r_ldist[dec_lslot] <= r_dist;
            end
        end
    end

    assign o_valid             = r_ovalid;
    assign o_status            = r_ostatus;
    assign o_entry_index       = r_oidx;
    assign o_entry_dist        = r_odist;
    assign o_entry_via         = r_ovia;
    assign o_entry_unreachable = r_odead;

endmodule

// ===== src/dvru_checker.sv =====
`timescale 1ns / 1ps
module dvru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [3:0]  o_status,
    input logic [5:0]  o_entry_index,
    input logic [7:0]  o_entry_dist,
    input logic [31:0] o_entry_via,
    input logic        o_entry_unreachable
);
    import dvru_pkg::*;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_NOT_FOUND)
        else $error("status code out of range");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted word neither worked on nor answered");

    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_INFINITE || o_status == ST_NO_SENDER ||
                     o_status == ST_FULL || o_status == ST_NOT_FOUND))
        |-> (o_entry_index == 6'd0 && o_entry_dist == 8'd0 &&
             o_entry_via == 32'd0 && !o_entry_unreachable))
        else $error("entry fields set on a result without an entry");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not quiet after reset");

endmodule

bind distance_vector_route_update_unit dvru_checker u_dvru_checker (.*);
